@@ design/quaternion_vector_rotation_top_macros.svh @@
`ifndef QUATERNION_VECTOR_ROTATION_TOP_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define QVR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define QVR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/qvr_pkg.sv @@
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int DATA_WIDTH     = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int QUAT_WIDTH     = 16;
    localparam int CFG_ADDR_W     = 2;
    localparam int NSTAGE         = 5;

    // Intermediate widths
    localparam int PROD_W = QUAT_WIDTH + DATA_WIDTH;      // x_i * v_j
    localparam int DOT_W  = PROD_W + 3;                   // 2 * (x . v)
    localparam int CR_W   = PROD_W + 1;                   // x cross v
    localparam int SQ_W   = 2 * QUAT_WIDTH;               // squares of quaternion parts
    localparam int A_W    = 2 * QUAT_WIDTH + 2;           // s^2 - |x|^2
    localparam int S2_W   = QUAT_WIDTH + 1;               // 2 * s
    localparam int TERM_W = PROD_W + QUAT_WIDTH + 3;
    localparam int SHIFT  = 2 * QUAT_FRAC_BITS;
    localparam int SUM_W  = (TERM_W + 2 > SHIFT + DATA_WIDTH + 1) ?
                            TERM_W + 2 : SHIFT + DATA_WIDTH + 1;
    localparam int RES_W  = SUM_W - SHIFT;
    localparam int TDATA_W = ((3 * DATA_WIDTH + 7) / 8) * 8;

    typedef logic signed [DATA_WIDTH-1:0] vec_t;
    typedef logic signed [QUAT_WIDTH-1:0] quat_t;
    typedef logic signed [TERM_W-1:0]     term_t;

    localparam vec_t VEC_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam vec_t VEC_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // 1.0 in the quaternion format, clipped when it does not fit
    localparam quat_t QUAT_W_RST = (QUAT_FRAC_BITS >= QUAT_WIDTH - 1) ?
                                   QUAT_WIDTH'((1 << (QUAT_WIDTH - 1)) - 1) :
                                   QUAT_WIDTH'(1 << QUAT_FRAC_BITS);
    localparam logic signed [SQ_W-1:0] SQ_W_RST =
        SQ_W'(int'(QUAT_W_RST) * int'(QUAT_W_RST));
    localparam logic signed [A_W-1:0] A_RST =
        A_W'(int'(QUAT_W_RST) * int'(QUAT_W_RST));

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (SHIFT - 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_X = 2'd1,
        REG_QUAT_Y = 2'd2,
        REG_QUAT_Z = 2'd3
    } cfg_reg_t;

    // Coefficients derived from the quaternion registers
    typedef struct packed {
        logic signed [A_W-1:0]  a;
        logic signed [S2_W-1:0] s2;
        quat_t                  qx;
        quat_t                  qy;
        quat_t                  qz;
    } qvr_coef_t;

    // Per-stage load strobes
    typedef struct packed {
        logic s5;
        logic s4;
        logic s3;
        logic s2;
        logic s1;
    } qvr_adv_t;

endpackage

@@ design/qvr_cfg.sv @@
`timescale 1ns / 1ps

module qvr_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [qvr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0] cfg_wdata,
    output qvr_pkg::qvr_coef_t             coef
);
    import qvr_pkg::*;

    quat_t quat_w_reg;
    quat_t quat_x_reg;
    quat_t quat_y_reg;
    quat_t quat_z_reg;

    logic signed [SQ_W-1:0] sqw_reg;
    logic signed [SQ_W-1:0] sqx_reg;
    logic signed [SQ_W-1:0] sqy_reg;
    logic signed [SQ_W-1:0] sqz_reg;
    logic signed [A_W-1:0]  a_reg;
    logic signed [A_W-1:0]  a_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_w_reg <= QUAT_W_RST;
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_QUAT_W: quat_w_reg <= cfg_wdata;
                REG_QUAT_X: quat_x_reg <= cfg_wdata;
                REG_QUAT_Y: quat_y_reg <= cfg_wdata;
                REG_QUAT_Z: quat_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // s^2 - |x|^2 settles through the square registers and then a_reg after a write, before any item needs it
    assign a_next = A_W'(sqw_reg) - (A_W'(sqx_reg) + A_W'(sqy_reg) + A_W'(sqz_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqw_reg <= SQ_W_RST;
            sqx_reg <= '0;
            sqy_reg <= '0;
            sqz_reg <= '0;
            a_reg   <= A_RST;
        end
        else
        begin
            sqw_reg <= SQ_W'(quat_w_reg) * SQ_W'(quat_w_reg);
            sqx_reg <= SQ_W'(quat_x_reg) * SQ_W'(quat_x_reg);
            sqy_reg <= SQ_W'(quat_y_reg) * SQ_W'(quat_y_reg);
            sqz_reg <= SQ_W'(quat_z_reg) * SQ_W'(quat_z_reg);
            a_reg   <= a_next;
        end
    end

    assign coef.a  = a_reg;
    assign coef.s2 = {quat_w_reg, 1'b0};
    assign coef.qx = quat_x_reg;
    assign coef.qy = quat_y_reg;
    assign coef.qz = quat_z_reg;

endmodule

@@ design/qvr_mul.sv @@
`timescale 1ns / 1ps

module qvr_mul
(
    input  logic               clk,
    input  qvr_pkg::qvr_adv_t  adv,
    input  qvr_pkg::qvr_coef_t coef,
    input  qvr_pkg::vec_t      vec_x,
    input  qvr_pkg::vec_t      vec_y,
    input  qvr_pkg::vec_t      vec_z,
    output qvr_pkg::term_t     term_a [3],
    output qvr_pkg::term_t     term_b [3],
    output qvr_pkg::term_t     term_c [3]
);
    import qvr_pkg::*;

    quat_t xq [3];

    // Stage 1: elementwise products
    logic signed [PROD_W-1:0] dot_reg [3];
    logic signed [PROD_W-1:0] crp_reg [3];
    logic signed [PROD_W-1:0] crn_reg [3];
    vec_t                     v1_reg  [3];

    // Stage 2: dot and cross products
    logic signed [DOT_W-1:0]  b2_reg;
    logic signed [CR_W-1:0]   cr_reg [3];
    vec_t                     v2_reg [3];

    // Stage 3: the three terms per component
    term_t ta_reg [3];
    term_t tb_reg [3];
    term_t tc_reg [3];

    assign xq[0] = coef.qx;
    assign xq[1] = coef.qy;
    assign xq[2] = coef.qz;

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            dot_reg[0] <= PROD_W'(coef.qx) * PROD_W'(vec_x);
            dot_reg[1] <= PROD_W'(coef.qy) * PROD_W'(vec_y);
            dot_reg[2] <= PROD_W'(coef.qz) * PROD_W'(vec_z);
            // cross = (y*vz - z*vy, z*vx - x*vz, x*vy - y*vx)
            crp_reg[0] <= PROD_W'(coef.qy) * PROD_W'(vec_z);
            crn_reg[0] <= PROD_W'(coef.qz) * PROD_W'(vec_y);
            crp_reg[1] <= PROD_W'(coef.qz) * PROD_W'(vec_x);
            crn_reg[1] <= PROD_W'(coef.qx) * PROD_W'(vec_z);
            crp_reg[2] <= PROD_W'(coef.qx) * PROD_W'(vec_y);
            crn_reg[2] <= PROD_W'(coef.qy) * PROD_W'(vec_x);
            v1_reg[0]  <= vec_x;
            v1_reg[1]  <= vec_y;
            v1_reg[2]  <= vec_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            b2_reg <= (DOT_W'(dot_reg[0]) + DOT_W'(dot_reg[1]) + DOT_W'(dot_reg[2])) <<< 1;
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i] <= CR_W'(crp_reg[i]) - CR_W'(crn_reg[i]);
                v2_reg[i] <= v1_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ta_reg[i] <= TERM_W'($signed(coef.a)) * TERM_W'(v2_reg[i]);
                tb_reg[i] <= TERM_W'(b2_reg) * TERM_W'(xq[i]);
                tc_reg[i] <= TERM_W'($signed(coef.s2)) * TERM_W'(cr_reg[i]);
            end
        end
    end

    assign term_a = ta_reg;
    assign term_b = tb_reg;
    assign term_c = tc_reg;

endmodule

@@ design/qvr_rnd.sv @@
`timescale 1ns / 1ps

module qvr_rnd
(
    input  logic              clk,
    input  qvr_pkg::qvr_adv_t adv,
    input  qvr_pkg::term_t    term_a [3],
    input  qvr_pkg::term_t    term_b [3],
    input  qvr_pkg::term_t    term_c [3],
    output qvr_pkg::vec_t     rot [3],
    output logic              saturated
);
    import qvr_pkg::*;

    logic signed [SUM_W-1:0]  sum_reg [3];
    logic signed [RES_W-1:0]  res     [3];
    logic [RES_W-DATA_WIDTH:0] hi     [3];
    logic [2:0]               ovf;
    vec_t                     rot_next [3];
    vec_t                     rot_reg  [3];
    logic                     sat_reg;

    // Stage 4: full-precision sum plus one half for round-half-up
    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= SUM_W'(term_a[i]) + SUM_W'(term_b[i])
                            + SUM_W'(term_c[i]) + RND_HALF;
        end
    end

    // Stage 5: drop fraction bits, clip to the data range
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res[i] = sum_reg[i][SUM_W-1:SHIFT];
            hi[i]  = res[i][RES_W-1:DATA_WIDTH-1];
            ovf[i] = !((&hi[i]) || !(|hi[i]));
            if (ovf[i])
                rot_next[i] = res[i][RES_W-1] ? VEC_MIN : VEC_MAX;
            else
                rot_next[i] = res[i][DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s5)
        begin
            rot_reg <= rot_next;
            sat_reg <= |ovf;
        end
    end

    assign rot       = rot_reg;
    assign saturated = sat_reg;

endmodule

@@ design/quaternion_vector_rotation_top.sv @@
`timescale 1ns / 1ps
// Rotates a stream of 3D vectors by the quaternion (w, x, y, z) held in four
// configuration registers (signed, QUAT_FRAC_BITS fraction bits; index 0..3 =
// w, x, y, z). Writes are taken on any edge with cfg_we high; write only
// while no vector is in flight and before the input transfer of the next vector.
// Input stream: s_axis_* carries vec_x/y/z. Output stream: m_axis_* carries
// rot_x/y/z plus the saturated flag in tuser.
// Result = (w^2-|x|^2)v + 2(x.v)x + 2w(x cross v), scaled down by
// 2^(2*QUAT_FRAC_BITS), rounded half up and clipped to DATA_WIDTH bits.
// An input transfer is registered in turn as products, dot and cross sums,
// coefficient products, final sum and the round/clip result in the output
// register, where it raises m_axis_tvalid and waits for the sink.
// Throughput: one vector per cycle while the sink takes data.
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up and a stalled sink fills all five stages before
// s_axis_tready drops; nothing is lost or repeated.
// Reset clears the pipeline and sets the quaternion to identity (w = 1.0).
module quaternion_vector_rotation_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [qvr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0] cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [qvr_pkg::TDATA_W-1:0]    s_axis_tdata,  // vec_x, vec_y, vec_z
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [qvr_pkg::TDATA_W-1:0]    m_axis_tdata,  // rot_x, rot_y, rot_z
    output logic                           m_axis_tuser   // saturated
);
    import qvr_pkg::*;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] stage_rdy;
    logic [NSTAGE-1:0] stage_in;
    logic [NSTAGE-1:0] load;
    qvr_adv_t          adv;
    qvr_coef_t         coef;
    term_t             term_a [3];
    term_t             term_b [3];
    term_t             term_c [3];
    vec_t              rot    [3];
    logic              saturated;

    always_comb
    begin
        stage_in = {valid_reg[NSTAGE-2:0], s_axis_tvalid};
        stage_rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        for (int k = 0; k < NSTAGE; k++)
            valid_next[k] = stage_rdy[k] ? stage_in[k] : valid_reg[k];
        load = stage_rdy & stage_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign adv.s1 = load[0];
    assign adv.s2 = load[1];
    assign adv.s3 = load[2];
    assign adv.s4 = load[3];
    assign adv.s5 = load[4];

    qvr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .coef      (coef)
    );

    qvr_mul u_mul
    (
        .clk    (clk),
        .adv    (adv),
        .coef   (coef),
        .vec_x  (s_axis_tdata[DATA_WIDTH-1:0]),
        .vec_y  (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .vec_z  (s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
        .term_a (term_a),
        .term_b (term_b),
        .term_c (term_c)
    );

    qvr_rnd u_rnd
    (
        .clk       (clk),
        .adv       (adv),
        .term_a    (term_a),
        .term_b    (term_b),
        .term_c    (term_c),
        .rot       (rot),
        .saturated (saturated)
    );

    assign s_axis_tready = stage_rdy[0];
    assign m_axis_tvalid = valid_reg[NSTAGE-1];
    assign m_axis_tdata  = TDATA_W'({rot[2], rot[1], rot[0]});
    assign m_axis_tuser  = saturated;

endmodule

@@ design/qvr_check.sv @@
`timescale 1ns / 1ps
`include "quaternion_vector_rotation_top_macros.svh"

module qvr_check
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [qvr_pkg::TDATA_W-1:0]    m_axis_tdata,
    input logic                           m_axis_tuser
);
    import qvr_pkg::*;

    logic s_xfer;
    logic sat_at_limit;
    vec_t rx;
    vec_t ry;
    vec_t rz;

    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign rx = m_axis_tdata[DATA_WIDTH-1:0];
    assign ry = m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign rz = m_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];
    assign sat_at_limit = (rx == VEC_MAX) || (rx == VEC_MIN) || (ry == VEC_MAX)
                       || (ry == VEC_MIN) || (rz == VEC_MAX) || (rz == VEC_MIN);

    // A waiting result holds still
    `QVR_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "output changed while stalled")

    // Flag set means at least one component sits at a range limit
    `QVR_ASSERT_IMP(a_sat_limit, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        sat_at_limit, "saturated set but no component at a limit")

    // Empty output stage never back-pressures the input
    `QVR_ASSERT_IMP(a_rdy_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready,
        "input stalled with output stage empty")

    // With the sink held open after an input transfer, a transfer is offered once the vector has passed all stages
    `QVR_ASSERT_NXT(a_latency, clk, rst_n,
        s_xfer ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready,
        m_axis_tvalid, "result missing after pipeline latency")

endmodule

bind quaternion_vector_rotation_top qvr_check u_qvr_check (.*);

@@ tb/sv/quaternion_vector_rotation_top_tb.sv @@
`timescale 1ns / 1ps

module quaternion_vector_rotation_top_tb;

    import qvr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NPHASE      = 12;
    localparam int PHASE_ITEMS = 108;
    localparam int HOLD_CYCLES = 64;

    typedef struct packed {
        logic sat;
        vec_t z;
        vec_t y;
        vec_t x;
    } rot_vec_t;

    class rotation_scoreboard;
        quat_t    qw, qx, qy, qz;
        rot_vec_t expected_q[$];
        int       mismatches;
        int       rotated;
        int       clipped;

        function new();
            qw = QUAT_W_RST;
            qx = '0;
            qy = '0;
            qz = '0;
            mismatches = 0;
            rotated = 0;
            clipped = 0;
        endfunction

        function void set_quat(cfg_reg_t idx, quat_t val);
            case (idx)
                REG_QUAT_W: qw = val;
                REG_QUAT_X: qx = val;
                REG_QUAT_Y: qy = val;
                REG_QUAT_Z: qz = val;
                default: ;
            endcase
        endfunction

        // drop the 2*frac bits with round half up, then clip to the data width
        function vec_t round_clip(longint acc, inout logic sat);
            longint t;
            t = (acc + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
            if (t > longint'(VEC_MAX)) begin
                sat = 1'b1;
                return VEC_MAX;
            end
            if (t < longint'(VEC_MIN)) begin
                sat = 1'b1;
                return VEC_MIN;
            end
            return vec_t'(t);
        endfunction

        function rot_vec_t predict_rotation(vec_t vx, vec_t vy, vec_t vz);
            longint   s, a, b2, acc;
            longint   v[3], q[3], cr[3];
            logic     sat;
            vec_t     o[3];
            rot_vec_t r;
            v[0] = vx;
            v[1] = vy;
            v[2] = vz;
            q[0] = qx;
            q[1] = qy;
            q[2] = qz;
            s = qw;
            sat = 1'b0;
            a  = s * s - (q[0] * q[0] + q[1] * q[1] + q[2] * q[2]);
            b2 = 2 * (q[0] * v[0] + q[1] * v[1] + q[2] * v[2]);
            cr[0] = q[1] * v[2] - q[2] * v[1];
            cr[1] = q[2] * v[0] - q[0] * v[2];
            cr[2] = q[0] * v[1] - q[1] * v[0];
            for (int i = 0; i < 3; i++) begin
                acc = a * v[i] + b2 * q[i] + 2 * s * cr[i];
                o[i] = round_clip(acc, sat);
            end
            r.x = o[0];
            r.y = o[1];
            r.z = o[2];
            r.sat = sat;
            return r;
        endfunction

        function void note_vector(vec_t vx, vec_t vy, vec_t vz);
            expected_q.push_back(predict_rotation(vx, vy, vz));
        endfunction

        function void check_result(vec_t rx, vec_t ry, vec_t rz, logic sat);
            rot_vec_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result (%0d, %0d, %0d) sat=%b",
                             rx, ry, rz, sat);
                return;
            end
            e = expected_q.pop_front();
            rotated++;
            if (e.sat)
                clipped++;
            if (rx !== e.x || ry !== e.y || rz !== e.z || sat !== e.sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d exp (%0d, %0d, %0d) sat=%b got (%0d, %0d, %0d) sat=%b",
                             rotated, e.x, e.y, e.z, e.sat, rx, ry, rz, sat);
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [QUAT_WIDTH-1:0]   cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [TDATA_W-1:0]      s_axis_tdata;   // vec_x, vec_y, vec_z
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [TDATA_W-1:0]      m_axis_tdata;   // rot_x, rot_y, rot_z
    logic                    m_axis_tuser;   // saturated

    rotation_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    int hold_left;
    int hold_count;
    int cycle_cnt;
    int settings;

    quaternion_vector_rotation_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // sink side: random stalls, plus a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left = 0;
        hold_count = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                hold_count++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(vec_t'(m_axis_tdata[DATA_WIDTH-1:0]),
                            vec_t'(m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
                            vec_t'(m_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
                            m_axis_tuser);
    end

    task automatic write_reg(cfg_reg_t idx, quat_t val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_quat(idx, val);
    endtask

    task automatic load_quat(quat_t w, quat_t x, quat_t y, quat_t z);
        write_reg(REG_QUAT_W, w);
        write_reg(REG_QUAT_X, x);
        write_reg(REG_QUAT_Y, y);
        write_reg(REG_QUAT_Z, z);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    task automatic send_vec(vec_t x, vec_t y, vec_t z, bit last);
        s_axis_tdata  <= TDATA_W'({z, y, x});
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_vector(x, y, z);
        if (last || $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            if (!last)
                do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    task automatic drain();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic vec_t rand_comp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return vec_t'($urandom);
        if (r < 90)
            return vec_t'($urandom_range(0, 511) - 256);
        case ($urandom_range(0, 3))
            0: return VEC_MAX;
            1: return VEC_MIN;
            2: return vec_t'(-1);
            default: return vec_t'(0);
        endcase
    endfunction

    function automatic quat_t extreme_part();
        case ($urandom_range(0, 4))
            0: return quat_t'(-32768);
            1: return quat_t'(32767);
            2: return quat_t'(16384);
            3: return quat_t'(-16384);
            default: return quat_t'(0);
        endcase
    endfunction

    task automatic random_quat(int kind);
        real   r[4];
        real   n;
        quat_t q[4];
        case (kind)
            0:
            begin
                // close to unit length, so results mostly stay in range
                do
                begin
                    n = 0.0;
                    for (int i = 0; i < 4; i++)
                    begin
                        r[i] = real'($urandom_range(0, 65535)) - 32768.0;
                        n += r[i] * r[i];
                    end
                end while (n < 1.0);
                n = $sqrt(n);
                for (int i = 0; i < 4; i++)
                    q[i] = quat_t'($rtoi(r[i] / n * 16383.0));
            end
            1:
                for (int i = 0; i < 4; i++)
                    q[i] = quat_t'($urandom);
            2:
                for (int i = 0; i < 4; i++)
                    q[i] = quat_t'($urandom_range(0, 8191) - 4096);
            default:
                for (int i = 0; i < 4; i++)
                    q[i] = extreme_part();
        endcase
        load_quat(q[0], q[1], q[2], q[3]);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        hold_req = 1'b0;
        cycle_cnt = 0;
        settings = 1;
        tx_idle_pct = 24;
        rx_idle_pct = 72;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity after reset: output equals input
        send_vec(vec_t'(0), vec_t'(0), vec_t'(0), 1'b0);
        send_vec(VEC_MAX, VEC_MAX, VEC_MAX, 1'b0);
        send_vec(VEC_MIN, VEC_MIN, VEC_MIN, 1'b0);
        send_vec(VEC_MAX, VEC_MIN, vec_t'(-1), 1'b0);
        send_vec(vec_t'(1), vec_t'(-1), vec_t'(21845), 1'b0);
        send_vec(vec_t'(-21846), vec_t'(12345), vec_t'(-1), 1'b1);
        drain();

        // w = 0.5 scales by 1/4: exact halves check the tie direction
        load_quat(quat_t'(8192), quat_t'(0), quat_t'(0), quat_t'(0));
        send_vec(vec_t'(2), vec_t'(-2), vec_t'(6), 1'b0);
        send_vec(vec_t'(-6), vec_t'(1), vec_t'(-1), 1'b0);
        send_vec(vec_t'(3), vec_t'(-3), vec_t'(5), 1'b1);
        drain();

        // 90 degrees about z
        load_quat(quat_t'(11585), quat_t'(0), quat_t'(0), quat_t'(11585));
        send_vec(vec_t'(1000), vec_t'(0), vec_t'(0), 1'b0);
        send_vec(vec_t'(0), VEC_MAX, vec_t'(0), 1'b0);
        send_vec(VEC_MIN, VEC_MIN, VEC_MAX, 1'b1);
        drain();

        // non-unit: gain of about 4, clips on both sides
        load_quat(quat_t'(32767), quat_t'(0), quat_t'(0), quat_t'(0));
        send_vec(vec_t'(1000), vec_t'(-1000), vec_t'(8191), 1'b0);
        send_vec(VEC_MAX, vec_t'(0), vec_t'(0), 1'b0);
        send_vec(vec_t'(0), VEC_MIN, vec_t'(0), 1'b1);
        drain();

        load_quat(quat_t'(-32768), quat_t'(-32768), quat_t'(-32768), quat_t'(-32768));
        send_vec(vec_t'(1), vec_t'(1), vec_t'(1), 1'b0);
        send_vec(VEC_MAX, VEC_MIN, vec_t'(0), 1'b1);
        drain();

        load_quat(quat_t'(32767), quat_t'(32767), quat_t'(32767), quat_t'(32767));
        send_vec(vec_t'(-1), vec_t'(2), vec_t'(-3), 1'b0);
        send_vec(VEC_MIN, VEC_MAX, VEC_MIN, 1'b1);
        drain();

        load_quat(quat_t'(0), quat_t'(0), quat_t'(0), quat_t'(0));
        send_vec(VEC_MAX, VEC_MAX, VEC_MIN, 1'b1);
        drain();

        for (int p = 0; p < NPHASE; p++)
        begin
            if (p < NPHASE / 3)
            begin
                tx_idle_pct = 24;
                rx_idle_pct = 72;
            end
            else if (p < 2 * NPHASE / 3)
            begin
                tx_idle_pct = 72;
                rx_idle_pct = 24;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_quat(p % 4);
            // stall the sink long enough to back the pipeline up to the input
            if (p % 4 == 1)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_vec(rand_comp(), rand_comp(), rand_comp(), i == PHASE_ITEMS - 1);
            drain();
        end

        repeat (NSTAGE + 4) @(posedge clk);
        $display("summary: %0d vectors checked over %0d quaternion settings, %0d clipped",
                 sb.rotated, settings, sb.clipped);
        $display("summary: %0d long sink hold-offs, %0d mismatches, %0d results missing",
                 hold_count, sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/qvr_pkg.sv
design/qvr_cfg.sv
design/qvr_mul.sv
design/qvr_rnd.sv
design/quaternion_vector_rotation_top.sv
design/qvr_check.sv
tb/sv/quaternion_vector_rotation_top_tb.sv
